/* design/mlsc_pkg.sv */
`default_nettype none

package mlsc_pkg;

  // Default sizes of the sensor bank.
  localparam int SENSORS_DEF     = 16;
  localparam int HISTORY_DEF     = 5;
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field widths and limits of the result stream.
  localparam int LEVEL_W = 16;
  localparam int SMP_W   = 12;
  localparam int OUT_MAX = 16;

  // Register reset values.
  localparam logic [15:0] FULL_SCALE_RST  = 16'd1000;
  localparam logic [15:0] STOP_BORDER_RST = 16'd500;

  // Register indexes.
  localparam logic CFG_FULL_SCALE  = 1'b0;
  localparam logic CFG_STOP_BORDER = 1'b1;

  // Input actions.
  localparam logic ACT_STORE  = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [3:0]  sensor_index;
    logic [11:0] sample;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_sensor;
    logic [11:0] median_value;
    logic [15:0] level;
    logic        emergency;
    logic        last;
  } out_item_t;

  // Commands from the sequencer to the median unit.
  typedef struct packed {
    logic load;
    logic go;
  } med_ctl_t;

endpackage

`default_nettype wire

/* design/mlsc_median.sv */
`default_nettype none

// Median by rank counting over a rotating shift line of HISTORY samples.
// Each candidate is compared against every sample, one per cycle, through a
// single comparator; the candidate whose rank is HISTORY/2 is the median.
module mlsc_median #(
  parameter int HISTORY     = mlsc_pkg::HISTORY_DEF,
  parameter int SAMPLE_BITS = mlsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mlsc_pkg::med_ctl_t      ctl_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  output logic                    done_o,
  output logic [SAMPLE_BITS-1:0]  median_o
);

  localparam int IW = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam logic [IW-1:0] LAST_POS = IW'(HISTORY - 1);
  localparam logic [IW-1:0] MID_RANK = IW'(HISTORY / 2);

  logic [SAMPLE_BITS-1:0] smp_q [HISTORY];
  logic [SAMPLE_BITS-1:0] cand_q;
  logic [SAMPLE_BITS-1:0] next_q;
  logic [SAMPLE_BITS-1:0] med_q;
  logic [SAMPLE_BITS-1:0] head;
  logic [IW-1:0]          pos_q;
  logic [IW-1:0]          phase_q;
  logic [IW-1:0]          cnt_q;
  logic [IW-1:0]          cnt_d;
  logic                   run_q;
  logic                   done_q;
  logic                   inc;
  logic                   take_next;

  // The head of the line shows sample number pos_q while ranking.
  assign head = smp_q[0];

  // A sample ranks below the candidate if smaller, or equal and earlier.
  assign inc       = (head < cand_q) || ((head == cand_q) && (pos_q < phase_q));
  assign cnt_d     = cnt_q + IW'(inc);
  assign take_next = ({1'b0, pos_q} == ({1'b0, phase_q} + 1'b1));

  // Shift line: filled from the history store, then rotated while ranking.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      for (int k = 0; k < HISTORY - 1; k++) begin
        smp_q[k] <= smp_q[k + 1];
      end
      smp_q[HISTORY - 1] <= sample_i;
    end else if (run_q) begin
      for (int k = 0; k < HISTORY - 1; k++) begin
        smp_q[k] <= smp_q[k + 1];
      end
      smp_q[HISTORY - 1] <= smp_q[0];
    end
  end

  // Candidate, the one that follows it, and the median found.
  always_ff @(posedge clk_i) begin
    if (ctl_i.go) begin
      cand_q <= head;
    end else if (run_q) begin
      if (take_next) begin
        next_q <= head;
      end
      if (pos_q == LAST_POS) begin
        if (cnt_d == MID_RANK) begin
          med_q <= cand_q;
        end
        cand_q <= take_next ? head : next_q;
      end
    end
  end

  // Position and phase counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      pos_q   <= '0;
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.go) begin
        run_q   <= 1'b1;
        pos_q   <= '0;
        phase_q <= '0;
        cnt_q   <= '0;
      end else if (run_q) begin
        if (pos_q == LAST_POS) begin
          pos_q <= '0;
          cnt_q <= '0;
          if (phase_q == LAST_POS) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end else begin
            phase_q <= phase_q + 1'b1;
          end
        end else begin
          pos_q <= pos_q + 1'b1;
          cnt_q <= cnt_d;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign median_o = med_q;

endmodule

`default_nettype wire

/* design/mlsc_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QW bits, so the upper DW bits of the dividend already
// form a partial remainder below the divisor.
module mlsc_div #(
  parameter int DW = mlsc_pkg::SAMPLE_BITS_DEF,
  parameter int QW = mlsc_pkg::LEVEL_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QW+DW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic             done_o,
  output logic [QW-1:0]    quot_o
);

  localparam int CW = $clog2(QW + 1);
  localparam logic [CW-1:0] STEPS = CW'(QW);

  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [QW-1:0] quo_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  // Bring down the next dividend bit and try a subtraction.
  assign trial = {rem_q, quo_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[QW+DW-1:QW];
      quo_q <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* design/median_autocal_line_sensor_core.sv */
`default_nettype none

// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+--------------------------
// in      | input     | in_valid_i / in_ready_o | in_data_i  (in_item_t)
// out     | output    | out_valid_o/ out_ready_i| out_data_o (out_item_t)
// cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// After reset the history and calibration stores are swept to zero, one entry
// a cycle; no transaction is taken meanwhile. An update walks the sensors in
// turn, ranking each history through the single rank comparator and scaling
// the level through the 16-step divider. The block takes no input while an
// update runs; a stalled output holds the sequencer in its emit or finish
// step, while one waiting result does not block input.
module median_autocal_line_sensor_core #(
  parameter int SENSORS     = mlsc_pkg::SENSORS_DEF,
  parameter int HISTORY     = mlsc_pkg::HISTORY_DEF,
  parameter int SAMPLE_BITS = mlsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mlsc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mlsc_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int DEPTH   = SENSORS * HISTORY;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW      = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int SLW     = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int LW      = $clog2(HISTORY + 1);
  localparam int SB      = SAMPLE_BITS;
  localparam int LVW     = mlsc_pkg::LEVEL_W;
  localparam int MW      = mlsc_pkg::SMP_W;
  localparam int RW      = 2 * SB + LVW;
  localparam int OUT_CNT = (SENSORS < mlsc_pkg::OUT_MAX) ? SENSORS : mlsc_pkg::OUT_MAX;

  localparam logic [AW-1:0]  CLR_LAST  = AW'(DEPTH - 1);
  localparam logic [AW-1:0]  HIST_STEP = AW'(HISTORY);
  localparam logic [SW-1:0]  S_LAST    = SW'(SENSORS - 1);
  localparam logic [SW-1:0]  OUT_LAST  = SW'(OUT_CNT - 1);
  localparam logic [SLW-1:0] SLOT_LAST = SLW'(HISTORY - 1);
  localparam logic [LW-1:0]  LD_LAST   = LW'(HISTORY);

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_LOAD      = 4'd2;
  localparam logic [3:0] ST_RANK_GO   = 4'd3;
  localparam logic [3:0] ST_RANK_WAIT = 4'd4;
  localparam logic [3:0] ST_CALC      = 4'd5;
  localparam logic [3:0] ST_MUL       = 4'd6;
  localparam logic [3:0] ST_DIV_GO    = 4'd7;
  localparam logic [3:0] ST_DIV_WAIT  = 4'd8;
  localparam logic [3:0] ST_EMIT      = 4'd9;
  localparam logic [3:0] ST_FIN       = 4'd10;

  logic [3:0]          state_q;
  logic [3:0]          state_d;
  logic [AW-1:0]       clr_q;
  logic [SLW-1:0]      slot_q;
  logic [SW-1:0]       s_q;
  logic [AW-1:0]       base_q;
  logic [LW-1:0]       ld_q;
  logic                emg_q;
  logic [15:0]         fs_q;
  logic [15:0]         sb_q;
  logic [SB-1:0]       pk_q;
  logic [SB-1:0]       fl_q;
  logic [LVW-1:0]      lv_q;
  logic [SB-1:0]       med_q;
  logic [LVW+SB-1:0]   prod_q;
  logic                out_vld_q;
  mlsc_pkg::out_item_t out_q;
  mlsc_pkg::out_item_t out_nx;
  mlsc_pkg::out_item_t pend_q;
  mlsc_pkg::out_item_t res_item;

  logic                in_acc;
  logic                store_ok;
  logic                out_free;
  logic                out_load;
  logic                adv;
  logic [SB-1:0]       smp_in;
  logic [AW-1:0]       store_addr;

  logic [SB-1:0]       hist_mem [DEPTH];
  logic [SB-1:0]       hist_rd_q;
  logic                hist_we;
  logic [AW-1:0]       hist_wa;
  logic [SB-1:0]       hist_wd;
  logic [AW-1:0]       hist_ra;

  logic [RW-1:0]       row_mem [SENSORS];
  logic [RW-1:0]       row_rd_q;
  logic                row_we;
  logic [SW-1:0]       row_wa;
  logic [RW-1:0]       row_wd;

  mlsc_pkg::med_ctl_t  med_ctl;
  logic                med_done;
  logic [SB-1:0]       med_out;
  logic [SB-1:0]       hi_calc;
  logic [SB-1:0]       lo_calc;
  logic [SB-1:0]       num;
  logic [SB-1:0]       den;
  logic                div_go;
  logic                div_done;
  logic [LVW-1:0]      div_quot;

  // Handshake and store addressing.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign store_ok   = (32'(in_data_i.sensor_index) < SENSORS);
  assign out_free   = !out_vld_q || out_ready_i;
  assign smp_in     = SB'(in_data_i.sample);
  assign store_addr = AW'(32'(in_data_i.sensor_index) * HISTORY + 32'(slot_q));
  assign hist_ra    = base_q + ((ld_q < LD_LAST) ? AW'(ld_q) : '0);

  // Calibration widening: a stored zero means the bound is not yet learned.
  assign hi_calc = ((pk_q < med_out) || (pk_q == '0)) ? med_out : pk_q;
  assign lo_calc = ((fl_q > med_out) || (fl_q == '0)) ? med_out : fl_q;
  assign num     = med_q - fl_q;
  assign den     = pk_q - fl_q;

  // Result of the sensor currently finishing.
  always_comb begin
    res_item              = '0;
    res_item.out_sensor   = 4'(s_q);
    res_item.median_value = MW'(med_q);
    res_item.level        = lv_q;
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    hist_we  = 1'b0;
    hist_wa  = store_addr;
    hist_wd  = smp_in;
    row_we   = 1'b0;
    row_wa   = s_q;
    row_wd   = {pk_q, fl_q, lv_q};
    med_ctl  = '0;
    div_go   = 1'b0;
    out_load = 1'b0;
    out_nx   = res_item;
    adv      = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        hist_we = 1'b1;
        hist_wa = clr_q;
        hist_wd = '0;
        if (32'(clr_q) < SENSORS) begin
          row_we = 1'b1;
          row_wa = clr_q[SW-1:0];
          row_wd = '0;
        end
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.action == mlsc_pkg::ACT_STORE) begin
            hist_we = store_ok;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        med_ctl.load = (ld_q != '0);
        if (ld_q == LD_LAST) begin
          state_d = ST_RANK_GO;
        end
      end
      ST_RANK_GO: begin
        med_ctl.go = 1'b1;
        state_d    = ST_RANK_WAIT;
      end
      ST_RANK_WAIT: begin
        if (med_done) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = (pk_q > fl_q) ? ST_DIV_GO : ST_EMIT;
      end
      ST_DIV_GO: begin
        div_go  = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if ((s_q >= OUT_LAST) || out_free) begin
          adv      = 1'b1;
          row_we   = 1'b1;
          out_load = (s_q < OUT_LAST);
          state_d  = (s_q == S_LAST) ? ST_FIN : ST_LOAD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_nx           = pend_q;
          out_nx.emergency = emg_q;
          out_nx.last      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      slot_q    <= '0;
      s_q       <= '0;
      base_q    <= '0;
      ld_q      <= '0;
      emg_q     <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (in_acc) begin
        if (in_data_i.action == mlsc_pkg::ACT_STORE) begin
          if (in_data_i.frame_end) begin
            slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
          end
        end else begin
          s_q    <= '0;
          base_q <= '0;
          ld_q   <= '0;
          emg_q  <= 1'b1;
        end
      end
      if (state_q == ST_LOAD) begin
        ld_q <= (ld_q == LD_LAST) ? '0 : ld_q + 1'b1;
      end
      if ((state_q == ST_DIV_WAIT) && div_done && (div_quot < sb_q)) begin
        emg_q <= 1'b0;
      end
      if (adv && (s_q != S_LAST)) begin
        s_q    <= s_q + 1'b1;
        base_q <= base_q + HIST_STEP;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= mlsc_pkg::FULL_SCALE_RST;
      sb_q <= mlsc_pkg::STOP_BORDER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlsc_pkg::CFG_FULL_SCALE:  fs_q <= cfg_data_i;
        mlsc_pkg::CFG_STOP_BORDER: sb_q <= cfg_data_i;
      endcase
    end
  end

  // Working data of the sensor in hand.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_LOAD) && (ld_q == LD_LAST)) begin
      pk_q <= row_rd_q[RW-1 -: SB];
      fl_q <= row_rd_q[LVW+SB-1 -: SB];
      lv_q <= row_rd_q[LVW-1:0];
    end
    if (state_q == ST_CALC) begin
      pk_q  <= hi_calc;
      fl_q  <= lo_calc;
      med_q <= med_out;
    end
    if (state_q == ST_MUL) begin
      prod_q <= {{SB{1'b0}}, fs_q} * {{LVW{1'b0}}, num};
    end
    if ((state_q == ST_DIV_WAIT) && div_done) begin
      lv_q <= div_quot;
    end
    if (adv && (s_q == OUT_LAST)) begin
      pend_q <= res_item;
    end
    if (out_load) begin
      out_q <= out_nx;
    end
  end

  // History store: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_q <= hist_mem[hist_ra];
  end

  // Calibration store: peak, floor and level of each sensor.
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    row_rd_q <= row_mem[s_q];
  end

  mlsc_median #(
    .HISTORY     (HISTORY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (med_ctl),
    .sample_i (hist_rd_q),
    .done_o   (med_done),
    .median_o (med_out)
  );

  mlsc_div #(
    .DW (SB),
    .QW (LVW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (prod_q),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Only the closing result of an update may carry the emergency flag.
  a_emg_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.last) |-> !out_q.emergency)
    else $error("emergency set on a result that is not the last");

  // The median unit finishes only while the sequencer waits for it.
  a_med_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    med_done |-> (state_q == ST_RANK_WAIT))
    else $error("median finished outside its wait state");

  // A fresh level never exceeds the full-scale value.
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == ST_DIV_WAIT) && (div_quot <= fs_q)))
    else $error("division result out of range or unexpected");

  // Handing out the last result returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_nx.last) |=> (state_q == ST_IDLE))
    else $error("sequencer not idle after the last result");
`endif

endmodule

`default_nettype wire
